### rtl/mandelbrot_escape_count_defines.svh
// ----------------------------------------------------------------------------
// mandelbrot_escape_count_defines.svh
// Assertion macros shared by the escape-count RTL.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_COUNT_DEFINES_SVH
`define MANDELBROT_ESCAPE_COUNT_DEFINES_SVH

// property checked every cycle outside reset
`define MEC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must hold in the cycle after the trigger
`define MEC_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

### rtl/mec_pkg.sv
// ----------------------------------------------------------------------------
// mec_pkg
// Types and constants shared by the escape-count controller and datapath.
// ----------------------------------------------------------------------------
package mec_pkg;

   localparam int POINT_W    = 32;
   localparam int WIDE_W     = 64;
   localparam int COUNT_W    = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_RE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_IM = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_RE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_IM   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ITER  = 3'd4;

   localparam logic [COUNT_W-1:0] MAX_ITER_RESET = 16'd256;

   typedef struct packed {
      logic load_coord;  // capture pixel coordinates
      logic do_map;      // form c, set z = c, clear count
      logic do_mul;      // register the three products
      logic do_step;     // write back new z, bump count
      logic load_out;    // copy count into the result register
   } mec_cmd_type;

   typedef struct packed {
      logic finished;    // escaped or limit reached on current z
   } mec_stat_type;

endpackage

### rtl/mandelbrot_escape_count.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_count
// Escape-time counter for one pixel at a time, Q3.28 fixed point.
//
// req channel: one beat per pixel, column and row in tdata. The point is
// c = origin + step * coordinate; z starts at c and z = z*z + c repeats until
// |z|^2 >= 4 or the count reaches max_iterations.
// rsp channel: one beat per pixel carrying the iteration count.
// csr port: write-only settings, index 0..4 = origin_re, origin_im, step_re,
// step_im, max_iterations; write only while no pixel is in flight.
// Sequence: a pixel is accepted, then mapped; each iteration registers the
// products on three 32x32 multipliers, then does the escape test and z
// update; a finished pixel loads its count into the result register, and
// the next pixel can be taken in the cycle after that load.
// The result register lets a new pixel start while the old count waits; if
// rsp stays stalled, the next pixel holds in its final state until the
// register frees. Reset clears the sequencer and the result valid, sets
// the origin and step settings to zero and max_iterations to 256.
// ----------------------------------------------------------------------------
module mandelbrot_escape_count
   import mec_pkg::*;
#(
   parameter int FRAC_BITS  = 28,
   parameter int COORD_BITS = 12,
   parameter int REQ_W      = ((2 * COORD_BITS + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_W-1:0]      req_tdata,   // pixel_column, pixel_row, zero pad
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [COUNT_W-1:0]    rsp_tdata,   // iteration_count
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   mec_cmd_type  cmd;
   mec_stat_type stat;

   mec_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   mec_datapath #(
      .FRAC_BITS  (FRAC_BITS),
      .COORD_BITS (COORD_BITS),
      .REQ_W      (REQ_W)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_tdata (rsp_tdata)
   );

endmodule

### rtl/mec_ctrl.sv
// ----------------------------------------------------------------------------
// mec_ctrl
// Sequencer: accepts a pixel, runs the multiply/update loop, hands the count
// to the result register.
// ----------------------------------------------------------------------------
`include "mandelbrot_escape_count_defines.svh"

module mec_ctrl
   import mec_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  mec_stat_type stat,
   output mec_cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MAP  = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_UPD  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_coord = 1'b1;
               state_in       = ST_MAP;
            end
         end
         ST_MAP: begin
            cmd.do_map = 1'b1;
            state_in   = ST_MUL;
         end
         ST_MUL: begin
            cmd.do_mul = 1'b1;
            state_in   = ST_UPD;
         end
         ST_UPD: begin
            if (stat.finished) begin
               state_in = ST_DONE;
            end else begin
               cmd.do_step = 1'b1;
               state_in    = ST_MUL;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `MEC_ASSERT(a_one_cmd, clock, reset, $onehot0(cmd), "more than one datapath command")
   `MEC_ASSERT(a_out_no_overwrite, clock, reset, !cmd.load_out || out_free,
      "result register overwritten while held")
   `MEC_ASSERT_NEXT(a_accept_maps, clock, reset, req_tvalid && req_tready,
      state_ff == ST_MAP && !req_tready, "accepted beat not followed by mapping")
   `MEC_ASSERT_NEXT(a_load_valid, clock, reset, cmd.load_out, rsp_tvalid,
      "loaded result not presented")

endmodule

### rtl/mec_datapath.sv
// ----------------------------------------------------------------------------
// mec_datapath
// Settings registers, point mapping, z*z + c iteration with escape test,
// iteration counter and result register.
// ----------------------------------------------------------------------------
module mec_datapath
   import mec_pkg::*;
#(
   parameter int FRAC_BITS  = 28,
   parameter int COORD_BITS = 12,
   parameter int REQ_W      = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [REQ_W-1:0]      req_tdata,
   input  mec_cmd_type           cmd,
   output mec_stat_type          stat,
   output logic [COUNT_W-1:0]    rsp_tdata
);

   localparam int MAP_W     = POINT_W + COORD_BITS + 1;
   localparam int ESC_SHIFT = 2 * FRAC_BITS + 2;
   localparam bit ESC_ON    = (ESC_SHIFT <= WIDE_W - 1);
   localparam logic [WIDE_W-1:0] ESC_LIMIT = ESC_ON ? (64'd1 << ESC_SHIFT) : 64'd0;
   localparam logic signed [WIDE_W-1:0] PT_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [WIDE_W-1:0] PT_MIN = -PT_MAX - 64'sd1;

   function automatic logic signed [POINT_W-1:0] sat_point(
      input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] r;
      r = v;
      if (v > PT_MAX) r = PT_MAX;
      if (v < PT_MIN) r = PT_MIN;
      return r[POINT_W-1:0];
   endfunction

   logic signed [POINT_W-1:0] origin_re_ff, origin_im_ff, step_re_ff, step_im_ff;
   logic [COUNT_W-1:0]        max_iter_ff;

   logic [COORD_BITS-1:0]     col_ff, row_ff;
   logic signed [POINT_W-1:0] cr_ff, ci_ff, zr_ff, zi_ff;
   logic signed [POINT_W-1:0] cr_in, ci_in, zr_in, zi_in;
   logic signed [WIDE_W-1:0]  rr_ff, ii_ff, ri_ff;
   logic signed [WIDE_W-1:0]  rr_in, ii_in, ri_in;
   logic [COUNT_W-1:0]        count_ff, out_ff;

   logic signed [MAP_W-1:0]   map_re_prod, map_im_prod;
   logic signed [WIDE_W-1:0]  map_re_sum, map_im_sum;
   logic signed [WIDE_W-1:0]  sq_diff, sq_shr, cross_shr, nr_sum, ni_sum;
   logic [WIDE_W-1:0]         mag;
   logic                      escaped;

   // settings
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_re_ff <= '0;
         origin_im_ff <= '0;
         step_re_ff   <= '0;
         step_im_ff   <= '0;
         max_iter_ff  <= MAX_ITER_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ORIGIN_RE: origin_re_ff <= csr_wdata[POINT_W-1:0];
            CSR_ORIGIN_IM: origin_im_ff <= csr_wdata[POINT_W-1:0];
            CSR_STEP_RE:   step_re_ff   <= csr_wdata[POINT_W-1:0];
            CSR_STEP_IM:   step_im_ff   <= csr_wdata[POINT_W-1:0];
            CSR_MAX_ITER:  max_iter_ff  <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // c = origin + step * coordinate
   assign map_re_prod = MAP_W'(step_re_ff) * MAP_W'($signed({1'b0, col_ff}));
   assign map_im_prod = MAP_W'(step_im_ff) * MAP_W'($signed({1'b0, row_ff}));
   assign map_re_sum  = WIDE_W'(map_re_prod) + WIDE_W'(origin_re_ff);
   assign map_im_sum  = WIDE_W'(map_im_prod) + WIDE_W'(origin_im_ff);
   assign cr_in       = sat_point(map_re_sum);
   assign ci_in       = sat_point(map_im_sum);

   // products of the current z
   assign rr_in = WIDE_W'(zr_ff) * WIDE_W'(zr_ff);
   assign ii_in = WIDE_W'(zi_ff) * WIDE_W'(zi_ff);
   assign ri_in = WIDE_W'(zr_ff) * WIDE_W'(zi_ff);

   // escape test and next z, from registered products
   assign mag       = rr_ff + ii_ff;
   assign escaped   = ESC_ON && (mag >= ESC_LIMIT);
   assign sq_diff   = rr_ff - ii_ff;
   assign sq_shr    = sq_diff >>> FRAC_BITS;
   assign cross_shr = ri_ff >>> (FRAC_BITS - 1);
   assign nr_sum    = sq_shr + WIDE_W'(cr_ff);
   assign ni_sum    = cross_shr + WIDE_W'(ci_ff);
   assign zr_in     = sat_point(nr_sum);
   assign zi_in     = sat_point(ni_sum);

   assign stat.finished = escaped || (count_ff >= max_iter_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_coord) begin
         col_ff <= req_tdata[COORD_BITS-1:0];
         row_ff <= req_tdata[2*COORD_BITS-1:COORD_BITS];
      end
      if (cmd.do_map) begin
         cr_ff    <= cr_in;
         ci_ff    <= ci_in;
         zr_ff    <= cr_in;
         zi_ff    <= ci_in;
         count_ff <= '0;
      end
      if (cmd.do_mul) begin
         rr_ff <= rr_in;
         ii_ff <= ii_in;
         ri_ff <= ri_in;
      end
      if (cmd.do_step) begin
         zr_ff    <= zr_in;
         zi_ff    <= zi_in;
         count_ff <= count_ff + COUNT_W'(1);
      end
      if (cmd.load_out) begin
         out_ff <= count_ff;
      end
   end

   assign rsp_tdata = out_ff;

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Mandelbrot escape-time counter.
//
// Pixels go in on the req stream, counts come back on the rsp stream. A
// scoreboard class recomputes each count in Q3.28 from its own copy of the
// settings and compares it with the returned beat in order. Settings are
// changed only with nothing in flight. A short directed run covers reset
// values, a zero limit, the escape boundary, saturated points, writes to
// unused indexes and the full 16-bit limit. Random phases follow, most
// framing a plausible view of the set, some with raw settings, with random
// gaps on both streams and at least one long rsp hold-off that backs up the req side.
// ----------------------------------------------------------------------------
module tb_top;
   import mec_pkg::*;

   localparam int       FRAC_BITS   = 28;
   localparam int       REQ_W       = 24;
   localparam longint   ONE         = 64'sd1 <<< FRAC_BITS;
   localparam longint   NEG_TWO     = -2 * ONE;
   localparam longint   STEP_4K     = (4 * ONE) / 4096;
   localparam int       RANDOM_ITEMS = 1000;
   localparam int       IDLE_GAP    = 8;
   localparam int       HOLD_CYCLES = 500;
   localparam int       CYCLE_LIMIT = 5000000;

   class count_board;
      longint            org_re, org_im, stp_re, stp_im;
      logic [COUNT_W-1:0] limit;
      logic [COUNT_W-1:0] expected_counts[$];
      logic [11:0]       pixel_cols[$];
      logic [11:0]       pixel_rows[$];
      int                errors;

      function new();
         org_re = 0;
         org_im = 0;
         stp_re = 0;
         stp_im = 0;
         limit  = MAX_ITER_RESET;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] v);
         case (idx)
            CSR_ORIGIN_RE: org_re = longint'($signed(v));
            CSR_ORIGIN_IM: org_im = longint'($signed(v));
            CSR_STEP_RE:   stp_re = longint'($signed(v));
            CSR_STEP_IM:   stp_im = longint'($signed(v));
            CSR_MAX_ITER:  limit  = v[COUNT_W-1:0];
            default: ;
         endcase
      endfunction

      function longint clip32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function logic [COUNT_W-1:0] escape_count(logic [11:0] col, logic [11:0] row);
         longint            cr, ci, zr, zi, sq, xprod;
         longint unsigned   mag;
         int unsigned       n;
         cr = clip32(org_re + stp_re * longint'(col));
         ci = clip32(org_im + stp_im * longint'(row));
         zr = cr;
         zi = ci;
         n  = 0;
         while (n < limit) begin
            mag = longint'(zr * zr) + longint'(zi * zi);
            if (2 * FRAC_BITS + 2 <= 63 && mag >= (64'd1 << (2 * FRAC_BITS + 2)))
               break;
            sq    = zr * zr - zi * zi;
            xprod = zr * zi;
            zr    = clip32((sq >>> FRAC_BITS) + cr);
            zi    = clip32((xprod >>> (FRAC_BITS - 1)) + ci);
            n++;
         end
         return n[COUNT_W-1:0];
      endfunction

      function void note_pixel(logic [11:0] col, logic [11:0] row);
         expected_counts.push_back(escape_count(col, row));
         pixel_cols.push_back(col);
         pixel_rows.push_back(row);
      endfunction

      function void check_count(logic [COUNT_W-1:0] got);
         logic [COUNT_W-1:0] want;
         logic [11:0]        col, row;
         if (expected_counts.size() == 0) begin
            $error("iteration_count %0d arrived with no pixel pending", got);
            errors++;
            return;
         end
         want = expected_counts.pop_front();
         col  = pixel_cols.pop_front();
         row  = pixel_rows.pop_front();
         if (got !== want) begin
            $error("iteration_count mismatch at pixel (%0d,%0d): expected %0d, actual %0d",
                   col, row, want, got);
            errors++;
         end
      endfunction

      function int pending();
         return expected_counts.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata;   // pixel_column, pixel_row
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [COUNT_W-1:0]    rsp_tdata;   // iteration_count
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   count_board board;
   bit         no_idle;
   int         hold_asks;
   int         holds_done;
   int         hold_left;
   int         stall_left;
   int         cycle_count;

   mandelbrot_escape_count dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic int idle_len();
      if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // rsp side: random stalls, plus the long hold-off when asked
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_count(rsp_tdata);
      if (holds_done != hold_asks) begin
         holds_done = hold_asks;
         hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 99) < 25) begin
         stall_left = idle_len() - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL mandelbrot_escape_count");
         $finish;
      end
   end

   task automatic send_pixel(logic [11:0] col, logic [11:0] row, int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {row, col};
      do @(posedge clock); while (!req_tready);
      board.note_pixel(col, row);
   endtask

   function automatic int sender_gap();
      if (no_idle || $urandom_range(0, 1) == 0) return 0;
      return idle_len();
   endfunction

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (IDLE_GAP) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] v);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      board.write_reg(idx, v);
   endtask

   task automatic load_settings(longint ore, longint oim, longint sre, longint sim,
                                int unsigned maxit, bit stray);
      csr_write(CSR_ORIGIN_RE, 32'(ore));
      csr_write(CSR_ORIGIN_IM, 32'(oim));
      csr_write(CSR_STEP_RE, 32'(sre));
      csr_write(CSR_STEP_IM, 32'(sim));
      csr_write(CSR_MAX_ITER, 32'(maxit));
      // unused indexes must leave every setting alone
      if (stray)
         for (int k = int'(CSR_MAX_ITER) + 1; k < (1 << CSR_IDX_W); k++)
            csr_write(CSR_IDX_W'(k), $urandom());
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_phase(int n_items, bit hold_off);
      longint      span, ctr_re, ctr_im, sre, sim, ore, oim;
      int          width, height, maxit, pick;
      logic [11:0] col, row;
      width  = $urandom_range(16, 4096);
      height = $urandom_range(16, 4096);
      pick   = $urandom_range(0, 19);
      if (pick == 0) maxit = 0;
      else if (pick < 5) maxit = $urandom_range(65, 300);
      else maxit = $urandom_range(1, 64);
      if ($urandom_range(0, 5) == 0) begin
         ore = longint'($signed($urandom()));
         oim = longint'($signed($urandom()));
         sre = longint'($signed($urandom()));
         sim = longint'($signed($urandom()));
      end else begin
         span   = longint'($urandom_range(1 << 26, 1 << 30)) >>> $urandom_range(0, 6);
         ctr_re = NEG_TWO + longint'($urandom_range(0, 11 << (FRAC_BITS - 2)));
         ctr_im = longint'($urandom_range(0, 3 << FRAC_BITS)) - (3 * ONE) / 2;
         sre    = span / width;
         sim    = span / height;
         ore    = ctr_re - span / 2;
         oim    = ctr_im - span / 2;
         if ($urandom_range(0, 3) == 0) begin
            sre = -sre;
            ore = ctr_re + span / 2;
         end
         if ($urandom_range(0, 3) == 0) begin
            sim = -sim;
            oim = ctr_im + span / 2;
         end
      end
      if (hold_off) maxit = $urandom_range(1, 12);
      load_settings(ore, oim, sre, sim, maxit, $urandom_range(0, 3) == 0);
      no_idle = hold_off || ($urandom_range(0, 4) == 0);
      if (hold_off) hold_asks++;
      for (int i = 0; i < n_items; i++) begin
         if ($urandom_range(0, 7) == 0) begin
            col = 12'($urandom());
            row = 12'($urandom());
         end else begin
            col = 12'($urandom_range(0, width - 1));
            row = 12'($urandom_range(0, height - 1));
         end
         send_pixel(col, row, sender_gap());
      end
      wait_idle();
   endtask

   initial begin
      int sent, n;
      board      = new();
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      rsp_tready <= 1'b0;
      csr_wr_en  <= 1'b0;
      csr_index  <= CSR_ORIGIN_RE;
      csr_wdata  <= '0;
      no_idle     = 1'b0;
      hold_asks   = 0;
      holds_done  = 0;
      hold_left   = 0;
      stall_left  = 0;
      cycle_count = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings: c = 0 everywhere, count hits 256
      send_pixel(12'd0, 12'd0, 0);
      send_pixel(12'hFFF, 12'hFFF, 1);
      wait_idle();

      // zero limit, with stray index writes
      load_settings(NEG_TWO, NEG_TWO, STEP_4K, STEP_4K, 0, 1);
      send_pixel(12'd0, 12'd0, 0);
      send_pixel(12'd2048, 12'd2048, 0);
      wait_idle();

      // full view of the set
      load_settings(NEG_TWO, NEG_TWO, STEP_4K, STEP_4K, 64, 0);
      send_pixel(12'd0, 12'd0, 0);
      send_pixel(12'd2048, 12'd2048, 0);
      send_pixel(12'd1024, 12'd2048, 2);
      send_pixel(12'd0, 12'd2048, 0);
      send_pixel(12'd2560, 12'd2048, 0);
      send_pixel(12'd1536, 12'd2600, 0);
      send_pixel(12'hFFF, 12'hFFF, 0);
      send_pixel(12'hAAA, 12'h555, 0);
      send_pixel(12'h555, 12'hAAA, 0);
      wait_idle();

      // just inside the escape circle at -2
      load_settings(NEG_TWO + 1, 0, 0, 0, 64, 0);
      send_pixel(12'd7, 12'd9, 0);
      wait_idle();

      // saturated points, both ends
      load_settings(64'sd2147483647, 64'sd2147483647, 64'sd2147483647,
                    64'sd2147483647, 16, 0);
      send_pixel(12'hFFF, 12'hFFF, 0);
      send_pixel(12'd0, 12'd0, 0);
      wait_idle();
      load_settings(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
                    -64'sd2147483648, 16, 1);
      send_pixel(12'hFFF, 12'hFFF, 0);
      send_pixel(12'd1, 12'd0, 0);
      wait_idle();

      // full 16-bit limit: one point that never escapes, one that does at once
      load_settings(0, 0, 0, 0, 65535, 0);
      send_pixel(12'd100, 12'd200, 0);
      wait_idle();
      load_settings(NEG_TWO, 0, 0, 0, 65535, 0);
      send_pixel(12'd3, 12'd3, 0);
      wait_idle();

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         n = $urandom_range(10, 40);
         run_phase(n, sent == 3 * 40 || sent == 0);
         sent += n;
      end

      wait_idle();
      if (board.errors == 0 && board.pending() == 0)
         $display("PASS mandelbrot_escape_count");
      else
         $display("FAIL mandelbrot_escape_count");
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl
rtl/mec_pkg.sv
rtl/mec_ctrl.sv
rtl/mec_datapath.sv
rtl/mandelbrot_escape_count.sv
tb/tb_top.sv
